// ===== hdl/sed_pkg.sv =====
// Shared types, constants and register codes of the speech endpoint detector.
package sed_pkg;

   localparam int STAMP_BITS_DEF = 48;
   localparam int ACC_BITS_DEF   = 32;

   localparam int LEVEL_BITS = 16;
   localparam int LEN_BITS   = 10;
   localparam int CSR_BITS   = 16;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_BITS-1:0] ONSET_LEVEL_RST  = 16'd32768;
   localparam logic [CSR_BITS-1:0] OFFSET_LEVEL_RST = 16'd22938;
   localparam logic [CSR_BITS-1:0] MIN_SPEECH_RST   = 16'd200;
   localparam logic [CSR_BITS-1:0] HANGOVER_RST     = 16'd500;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ONSET_LEVEL  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OFFSET_LEVEL = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_SPEECH   = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HANGOVER     = 2'd3;

   typedef enum logic [1:0] {
      PH_QUIET = 2'd0,
      PH_ONSET = 2'd1,
      PH_SPEAK = 2'd2,
      PH_HANG  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      OUT_NONE  = 2'd0,
      OUT_START = 2'd1,
      OUT_FALSE = 2'd2,
      OUT_END   = 2'd3
   } outcome_type;

   typedef enum logic {
      CMD_FRAME = 1'b0,
      CMD_FORCE = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] onset_level;
      logic [LEVEL_BITS-1:0] offset_level;
      logic [CSR_BITS-1:0]   min_speech_time;
      logic [CSR_BITS-1:0]   hangover_time;
   } cfg_type;

endpackage

// ===== hdl/sed_csr.sv =====
// Configuration registers: thresholds and time limits.
module sed_csr
   import sed_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ONSET_LEVEL:  cfg_in.onset_level     = csr_wdata;
            CSR_OFFSET_LEVEL: cfg_in.offset_level    = csr_wdata;
            CSR_MIN_SPEECH:   cfg_in.min_speech_time = csr_wdata;
            CSR_HANGOVER:     cfg_in.hangover_time   = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.onset_level     <= ONSET_LEVEL_RST;
         cfg_ff.offset_level    <= OFFSET_LEVEL_RST;
         cfg_ff.min_speech_time <= MIN_SPEECH_RST;
         cfg_ff.hangover_time   <= HANGOVER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/sed_step.sv =====
// Next-state logic of the endpointer for one frame or force command.
module sed_step
   import sed_pkg::*;
#(
   parameter int STAMP_BITS = STAMP_BITS_DEF,
   parameter int ACC_BITS   = ACC_BITS_DEF
)(
   input  cfg_type               cfg,
   input  cmd_type               cmd,
   input  logic [LEVEL_BITS-1:0] level,
   input  logic [LEN_BITS-1:0]   len,
   input  logic [STAMP_BITS-1:0] stamp,
   input  phase_type             phase,
   input  logic [ACC_BITS-1:0]   speech_acc,
   input  logic [ACC_BITS-1:0]   quiet_acc,
   input  logic [STAMP_BITS-1:0] start_time,
   input  logic [STAMP_BITS-1:0] end_time,
   output outcome_type           outcome_nxt,
   output phase_type             phase_nxt,
   output logic [ACC_BITS-1:0]   speech_acc_nxt,
   output logic [ACC_BITS-1:0]   quiet_acc_nxt,
   output logic [STAMP_BITS-1:0] start_time_nxt,
   output logic [STAMP_BITS-1:0] end_time_nxt
);

   logic [ACC_BITS-1:0] len_ext;
   logic [ACC_BITS:0]   speech_sum;
   logic [ACC_BITS:0]   quiet_sum;
   logic [ACC_BITS-1:0] speech_add;
   logic [ACC_BITS-1:0] quiet_add;
   logic [ACC_BITS-1:0] min_speech_ext;
   logic [ACC_BITS-1:0] hangover_ext;
   logic                hi;
   logic                lo;

   assign len_ext        = {{(ACC_BITS-LEN_BITS){1'b0}}, len};
   assign min_speech_ext = ACC_BITS'(cfg.min_speech_time);
   assign hangover_ext   = ACC_BITS'(cfg.hangover_time);

   // saturating adds: a carry out pins the total at all ones
   assign speech_sum = {1'b0, speech_acc} + {1'b0, len_ext};
   assign quiet_sum  = {1'b0, quiet_acc} + {1'b0, len_ext};
   assign speech_add = speech_sum[ACC_BITS] ? {ACC_BITS{1'b1}} : speech_sum[ACC_BITS-1:0];
   assign quiet_add  = quiet_sum[ACC_BITS] ? {ACC_BITS{1'b1}} : quiet_sum[ACC_BITS-1:0];

   // speech test wins when the thresholds cross
   assign hi = level >= cfg.onset_level;
   assign lo = level < cfg.offset_level;

   always_comb begin
      outcome_nxt    = OUT_NONE;
      phase_nxt      = phase;
      speech_acc_nxt = speech_acc;
      quiet_acc_nxt  = quiet_acc;
      start_time_nxt = start_time;
      end_time_nxt   = end_time;
      if (cmd == CMD_FORCE) begin
         unique case (phase)
            PH_SPEAK, PH_HANG: begin
               end_time_nxt = stamp;
               phase_nxt    = PH_QUIET;
               outcome_nxt  = OUT_END;
            end
            PH_ONSET: begin
               phase_nxt   = PH_QUIET;
               outcome_nxt = OUT_FALSE;
            end
            default: begin
               phase_nxt = phase;
            end
         endcase
      end else begin
         unique case (phase)
            PH_QUIET: begin
               if (hi) begin
                  phase_nxt      = PH_ONSET;
                  speech_acc_nxt = len_ext;
                  quiet_acc_nxt  = '0;
                  start_time_nxt = stamp;
               end
            end
            PH_ONSET: begin
               priority if (hi) begin
                  speech_acc_nxt = speech_add;
                  if (speech_add >= min_speech_ext) begin
                     phase_nxt     = PH_SPEAK;
                     quiet_acc_nxt = '0;
                     outcome_nxt   = OUT_START;
                  end
               end else if (lo) begin
                  phase_nxt      = PH_QUIET;
                  speech_acc_nxt = '0;
                  quiet_acc_nxt  = '0;
                  start_time_nxt = '0;
                  outcome_nxt    = OUT_FALSE;
               end
            end
            PH_SPEAK: begin
               priority if (hi) begin
                  speech_acc_nxt = speech_add;
                  quiet_acc_nxt  = '0;
               end else if (lo) begin
                  phase_nxt     = PH_HANG;
                  quiet_acc_nxt = len_ext;
                  end_time_nxt  = stamp;
               end else begin
                  speech_acc_nxt = speech_add;
               end
            end
            default: begin
               if (hi) begin
                  phase_nxt      = PH_SPEAK;
                  speech_acc_nxt = speech_add;
                  quiet_acc_nxt  = '0;
                  end_time_nxt   = '0;
               end else begin
                  quiet_acc_nxt = quiet_add;
                  if (quiet_add >= hangover_ext) begin
                     phase_nxt   = PH_QUIET;
                     outcome_nxt = OUT_END;
                  end
               end
            end
         endcase
      end
   end

endmodule

// ===== hdl/speech_endpoint_detector_unit.sv =====
// Top level of the speech endpoint detector: input register, state, result register.
//
//   channel  direction  fields
//   req_     in         tuser: cmd; tdata: vad_level, frame_length, stamp
//   rsp_     out        tuser: outcome; tdata: phase, speech_total, quiet_total,
//                       start_stamp, end_stamp
//   csr_     in         write enable, register index, 16-bit data
//
// One word per cycle unless rsp stalls; rsp valid is registered after the input register.
// The state update is one compare-and-add pass between the input register and
// the state/result registers. Result fields are read straight from the state
// registers, which only move when the result slot is free or being taken.
// Synchronous reset returns the phase to quiet, clears totals and stamps and
// loads the register defaults. A stalled rsp backs up into the input register,
// then req_tready drops.
module speech_endpoint_detector_unit
   import sed_pkg::*;
#(
   parameter int STAMP_BITS = STAMP_BITS_DEF,
   parameter int ACC_BITS   = ACC_BITS_DEF,
   localparam int REQ_RAW   = LEVEL_BITS + LEN_BITS + STAMP_BITS,
   localparam int REQ_BITS  = ((REQ_RAW + 7) / 8) * 8,
   localparam int RSP_RAW   = 2 + 2 * ACC_BITS + 2 * STAMP_BITS,
   localparam int RSP_BITS  = ((RSP_RAW + 7) / 8) * 8
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_BITS-1:0]     req_tdata,  // vad_level, frame_length, stamp, zero pad
   input  logic                    req_tuser,  // cmd
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_BITS-1:0]     rsp_tdata,  // phase, speech_total, quiet_total,
                                               // start_stamp, end_stamp, zero pad
   output logic [1:0]              rsp_tuser,  // outcome
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wdata
);

   localparam int LEN_LSB   = LEVEL_BITS;
   localparam int STAMP_LSB = LEVEL_BITS + LEN_BITS;

   cfg_type cfg;

   // input register
   logic                  in_valid_ff, in_valid_in;
   cmd_type               in_cmd_ff;
   logic [LEVEL_BITS-1:0] in_level_ff;
   logic [LEN_BITS-1:0]   in_len_ff;
   logic [STAMP_BITS-1:0] in_stamp_ff;

   // state, doubling as result payload
   phase_type             phase_ff, phase_in;
   logic [ACC_BITS-1:0]   speech_acc_ff, speech_acc_in;
   logic [ACC_BITS-1:0]   quiet_acc_ff, quiet_acc_in;
   logic [STAMP_BITS-1:0] start_time_ff, start_time_in;
   logic [STAMP_BITS-1:0] end_time_ff, end_time_in;
   outcome_type           outcome_ff, outcome_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic req_take;
   logic adv;
   logic rsp_free;

   sed_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sed_step #(
      .STAMP_BITS (STAMP_BITS),
      .ACC_BITS   (ACC_BITS)
   ) u_step (
      .cfg            (cfg),
      .cmd            (in_cmd_ff),
      .level          (in_level_ff),
      .len            (in_len_ff),
      .stamp          (in_stamp_ff),
      .phase          (phase_ff),
      .speech_acc     (speech_acc_ff),
      .quiet_acc      (quiet_acc_ff),
      .start_time     (start_time_ff),
      .end_time       (end_time_ff),
      .outcome_nxt    (outcome_in),
      .phase_nxt      (phase_in),
      .speech_acc_nxt (speech_acc_in),
      .quiet_acc_nxt  (quiet_acc_in),
      .start_time_nxt (start_time_in),
      .end_time_nxt   (end_time_in)
   );

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign adv        = in_valid_ff && rsp_free;
   assign req_tready = !in_valid_ff || rsp_free;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !adv);
   assign rsp_valid_in = adv || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_QUIET;
         speech_acc_ff <= '0;
         quiet_acc_ff  <= '0;
         start_time_ff <= '0;
         end_time_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            phase_ff      <= phase_in;
            speech_acc_ff <= speech_acc_in;
            quiet_acc_ff  <= quiet_acc_in;
            start_time_ff <= start_time_in;
            end_time_ff   <= end_time_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff   <= cmd_type'(req_tuser);
         in_level_ff <= req_tdata[LEVEL_BITS-1:0];
         in_len_ff   <= req_tdata[STAMP_LSB-1:LEN_LSB];
         in_stamp_ff <= req_tdata[STAMP_LSB+STAMP_BITS-1:STAMP_LSB];
      end
      if (adv) begin
         outcome_ff <= outcome_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = outcome_ff;

   // pad width may be zero for some parameter choices
   always_comb begin
      rsp_tdata              = '0;
      rsp_tdata[RSP_RAW-1:0] = {end_time_ff, start_time_ff, quiet_acc_ff, speech_acc_ff,
                                phase_ff};
   end

endmodule
